// File: rtl/bcip_pkg.sv
// ----------------------------------------------------------------------------
// bcip_pkg
// Shared types for the best cover interval pair block: controller commands,
// datapath status and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package bcip_pkg;

	// Fixed widths of the result fields
	localparam int IDX_OUT_W   = 6;
	localparam int COVER_OUT_W = 17;
	localparam int POS_OUT_W   = 16;

	typedef logic [IDX_OUT_W-1:0]   idx_out_t;
	typedef logic [COVER_OUT_W-1:0] cover_out_t;
	typedef logic [POS_OUT_W-1:0]   pos_out_t;

	// Region store read address select
	typedef enum logic [2:0] {
		RD_K,    // sort key position
		RD_KM1,  // entry below the sort key
		RD_MM2,  // two below the current hole
		RD_I,    // first region of the pair
		RD_TOP,  // highest stored region
		RD_JM1   // next second region, walking down
	} rd_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    load;      // store the incoming region
		logic    init;      // prepare sort and search of a new set
		logic    rd_en;     // read the region store
		rd_sel_t rd_sel;
		logic    key_load;  // capture sort key, open hole at its position
		logic    shift;     // move the read entry up into the hole
		logic    place;     // drop the key into the hole, advance key
		logic    ilat;      // capture first region, start second at top
		logic    jfeed;     // push a pair into the cover pipeline
		logic    finish;    // publish the result
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic k_done;  // every key inserted
		logic gt;      // read entry begins after the key
		logic m_one;   // hole is at position one
		logic i_done;  // no first region left with a partner
		logic j_last;  // second region is adjacent to the first
	} status_t;

endpackage

// File: rtl/bcip_ctrl.sv
// ----------------------------------------------------------------------------
// bcip_ctrl
// Sequencer for the block: load, insertion sort over the region store and
// the pair search, issuing one command word to the datapath each cycle.
// ----------------------------------------------------------------------------
module bcip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_region,
	input  bcip_pkg::status_t status,
	output bcip_pkg::cmd_t    cmd,
	output logic              busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SORT_NEXT,
		S_SORT_KEY,
		S_SORT_CMP,
		S_SORT_INS,
		S_SRCH_NEXT,
		S_SRCH_ILAT,
		S_SRCH_J,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   busy_q;

	// Decode commands and next state
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = bcip_pkg::RD_K;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_region) begin
						cmd.init   = 1'b1;
						state_next = S_SORT_NEXT;
					end
				end
			end
			S_SORT_NEXT: begin
				if (status.k_done) begin
					state_next = S_SRCH_NEXT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bcip_pkg::RD_K;
					state_next = S_SORT_KEY;
				end
			end
			S_SORT_KEY: begin
				cmd.key_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = bcip_pkg::RD_KM1;
				state_next   = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				if (status.gt) begin
					cmd.shift = 1'b1;
					if (status.m_one) begin
						state_next = S_SORT_INS;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = bcip_pkg::RD_MM2;
					end
				end else begin
					cmd.place  = 1'b1;
					state_next = S_SORT_NEXT;
				end
			end
			S_SORT_INS: begin
				cmd.place  = 1'b1;
				state_next = S_SORT_NEXT;
			end
			S_SRCH_NEXT: begin
				if (status.i_done) begin
					state_next = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bcip_pkg::RD_I;
					state_next = S_SRCH_ILAT;
				end
			end
			S_SRCH_ILAT: begin
				cmd.ilat   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bcip_pkg::RD_TOP;
				state_next = S_SRCH_J;
			end
			S_SRCH_J: begin
				cmd.jfeed = 1'b1;
				if (status.j_last) begin
					state_next = S_SRCH_NEXT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bcip_pkg::RD_JM1;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Hold state and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			busy_q  <= (state_next != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// File: rtl/bcip_dpath.sv
// ----------------------------------------------------------------------------
// bcip_dpath
// Region store, sort and search index counters, pair cover pipeline and the
// best pair registers that drive the result.
// ----------------------------------------------------------------------------
module bcip_dpath #(
	parameter int MAX_REGIONS   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bcip_pkg::cmd_t           cmd,
	output bcip_pkg::status_t        status,
	input  logic [POSITION_BITS-1:0] region_begin,
	input  logic [POSITION_BITS-1:0] region_length,
	output logic                     done,
	output logic                     pair_found,
	output bcip_pkg::idx_out_t       first_index,
	output bcip_pkg::idx_out_t       second_index,
	output bcip_pkg::cover_out_t     covered_length,
	output bcip_pkg::pos_out_t       first_begin,
	output bcip_pkg::pos_out_t       first_length,
	output bcip_pkg::pos_out_t       second_begin,
	output bcip_pkg::pos_out_t       second_length
);

	localparam int P  = POSITION_BITS;
	localparam int AW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] ONE_C  = CW'(1);
	localparam logic [CW-1:0] TWO_C  = CW'(2);
	localparam logic [CW-1:0] FULL_C = CW'(MAX_REGIONS);

	typedef struct packed {
		logic [P-1:0] rbegin;
		logic [P-1:0] rlen;
	} entry_t;

	// Region store
	entry_t mem [MAX_REGIONS];
	entry_t rd_q;
	entry_t wr_data;
	logic   wr_en;
	logic [CW-1:0] wr_idx;
	logic [CW-1:0] rd_idx;

	// Counters
	logic [CW-1:0] cnt_q, k_q, m_q, i_q, j_q;

	// Sort key and first region of the pair
	entry_t     key_q;
	entry_t     ri_q;
	logic [P:0] ei_q;

	// Cover pipeline
	logic          v_s1;
	logic [P:0]    cover_s1;
	logic [CW-1:0] i_s1, j_s1;
	entry_t        ri_s1, rj_s1;
	logic [P:0]    cover_c;
	logic          olap_c;
	logic          upd_c;

	// Best pair so far
	logic          found_q;
	logic          done_q;
	logic [P:0]    max_cover_q;
	logic [CW-1:0] best_i_q, best_j_q;
	entry_t        best_ri_q, best_rj_q;

	// Select store addresses and write data
	always_comb begin
		case (cmd.rd_sel)
			bcip_pkg::RD_K:   rd_idx = k_q;
			bcip_pkg::RD_KM1: rd_idx = k_q - ONE_C;
			bcip_pkg::RD_MM2: rd_idx = m_q - TWO_C;
			bcip_pkg::RD_I:   rd_idx = i_q;
			bcip_pkg::RD_TOP: rd_idx = cnt_q - ONE_C;
			bcip_pkg::RD_JM1: rd_idx = j_q - ONE_C;
			default:          rd_idx = k_q;
		endcase
		wr_en  = (cmd.load && (cnt_q < FULL_C)) || cmd.shift || cmd.place;
		wr_idx = cmd.load ? cnt_q : m_q;
		if (cmd.load) begin
			wr_data = '{rbegin: region_begin, rlen: region_length};
		end else if (cmd.shift) begin
			wr_data = rd_q;
		end else begin
			wr_data = key_q;
		end
	end

	// Write and read the store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_idx[AW-1:0]];
		end
	end

	// Status for the controller
	assign status.k_done = (k_q >= cnt_q);
	assign status.gt     = (rd_q.rbegin > key_q.rbegin);
	assign status.m_one  = (m_q == ONE_C);
	assign status.i_done = ((i_q + ONE_C) >= cnt_q);
	assign status.j_last = (j_q == (i_q + ONE_C));

	// Cover of the current pair: clip the overlap when the first runs past
	always_comb begin
		olap_c = (ei_q > {1'b0, rd_q.rbegin});
		if (olap_c) begin
			cover_c = {1'b0, rd_q.rbegin - ri_q.rbegin} + {1'b0, rd_q.rlen};
		end else begin
			cover_c = {1'b0, ri_q.rlen} + {1'b0, rd_q.rlen};
		end
		upd_c = v_s1 && (!found_q || (cover_s1 > max_cover_q));
	end

	// Control registers: counters, pipeline valid, found flag, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			k_q     <= '0;
			m_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			v_s1    <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1   <= cmd.jfeed;
			done_q <= cmd.finish;
			if (cmd.load && (cnt_q < FULL_C)) begin
				cnt_q <= cnt_q + ONE_C;
			end else if (cmd.finish) begin
				cnt_q <= '0;
			end
			if (cmd.init) begin
				k_q <= ONE_C;
			end else if (cmd.place) begin
				k_q <= k_q + ONE_C;
			end
			if (cmd.key_load) begin
				m_q <= k_q;
			end else if (cmd.shift) begin
				m_q <= m_q - ONE_C;
			end
			if (cmd.init) begin
				i_q <= '0;
			end else if (cmd.jfeed && status.j_last) begin
				i_q <= i_q + ONE_C;
			end
			if (cmd.ilat) begin
				j_q <= cnt_q - ONE_C;
			end else if (cmd.jfeed && !status.j_last) begin
				j_q <= j_q - ONE_C;
			end
			if (cmd.init) begin
				found_q <= 1'b0;
			end else if (upd_c) begin
				found_q <= 1'b1;
			end
		end
	end

	// Payload: sort key, first region, cover pipeline, best pair
	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= rd_q;
		end
		if (cmd.ilat) begin
			ri_q <= rd_q;
			ei_q <= {1'b0, rd_q.rbegin} + {1'b0, rd_q.rlen};
		end
		if (cmd.jfeed) begin
			cover_s1 <= cover_c;
			i_s1     <= i_q;
			j_s1     <= j_q;
			ri_s1    <= ri_q;
			rj_s1    <= rd_q;
		end
		if (cmd.init) begin
			max_cover_q <= '0;
			best_i_q    <= '0;
			best_j_q    <= '0;
			best_ri_q   <= '0;
			best_rj_q   <= '0;
		end else if (upd_c) begin
			max_cover_q <= cover_s1;
			best_i_q    <= i_s1;
			best_j_q    <= j_s1;
			best_ri_q   <= ri_s1;
			best_rj_q   <= rj_s1;
		end
	end

	// Drive the result
	assign done           = done_q;
	assign pair_found     = found_q;
	assign first_index    = bcip_pkg::idx_out_t'(best_i_q);
	assign second_index   = bcip_pkg::idx_out_t'(best_j_q);
	assign covered_length = bcip_pkg::cover_out_t'(max_cover_q);
	assign first_begin    = bcip_pkg::pos_out_t'(best_ri_q.rbegin);
	assign first_length   = bcip_pkg::pos_out_t'(best_ri_q.rlen);
	assign second_begin   = bcip_pkg::pos_out_t'(best_rj_q.rbegin);
	assign second_length  = bcip_pkg::pos_out_t'(best_rj_q.rlen);

endmodule

// File: rtl/best_cover_interval_pair.sv
// ----------------------------------------------------------------------------
// best_cover_interval_pair
// Finds the pair of query regions whose union covers the most positions.
// ----------------------------------------------------------------------------
// Usage:
//   Regions enter as transactions on start (taken when busy is low): one
//   region per cycle, the last of a set marked by last_region. Regions past
//   MAX_REGIONS are dropped, but their last mark still closes the set.
//   After the last region busy rises while the stored set is insertion
//   sorted by begin (stable) and every pair is scored. The sort is limited
//   by the single read and write port of the region store; the search
//   scores one pair per cycle while it walks the second regions of one
//   first region. The finish state then publishes the result, and done
//   pulses for one cycle right after it; busy is low again in that cycle,
//   so the next set may begin loading at once.
//   The result fields are valid while done is high and hold until the
//   last region of the next set; the receiver cannot stall them. Reset
//   clears the region count and the search state; the region store itself
//   is not cleared.
// ----------------------------------------------------------------------------
module best_cover_interval_pair #(
	parameter int MAX_REGIONS   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [POSITION_BITS-1:0] region_begin,
	input  logic [POSITION_BITS-1:0] region_length,
	input  logic                     last_region,
	output logic                     done,
	output logic                     pair_found,
	output bcip_pkg::idx_out_t       first_index,
	output bcip_pkg::idx_out_t       second_index,
	output bcip_pkg::cover_out_t     covered_length,
	output bcip_pkg::pos_out_t       first_begin,
	output bcip_pkg::pos_out_t       first_length,
	output bcip_pkg::pos_out_t       second_begin,
	output bcip_pkg::pos_out_t       second_length
);

	bcip_pkg::cmd_t    cmd;
	bcip_pkg::status_t status;

	bcip_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_region (last_region),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy)
	);

	bcip_dpath #(
		.MAX_REGIONS   (MAX_REGIONS),
		.POSITION_BITS (POSITION_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.region_begin   (region_begin),
		.region_length  (region_length),
		.done           (done),
		.pair_found     (pair_found),
		.first_index    (first_index),
		.second_index   (second_index),
		.covered_length (covered_length),
		.first_begin    (first_begin),
		.first_length   (first_length),
		.second_begin   (second_begin),
		.second_length  (second_length)
	);

	// A region that does not close the set keeps the block taking regions
	a_mid_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_region |=> !busy)
		else $error("busy rose on a region that does not close the set");

	// Closing the set starts the sort and search
	a_last_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_region |=> busy)
		else $error("busy did not rise after the last region");

	// One result per set, a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// The result is shown only once the search has released the block
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done while busy or without a preceding search");

endmodule
